/* rtl/core/ata_pio_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ata_pio_pkg;

	localparam int WORDS_PER_SECTOR = 256;
	localparam int MAX_SECTORS      = 255;
	localparam int DELAY_READS      = 4;
	localparam int MAX_RESULTS      = 8;

	localparam int IN_TDATA_W  = 64;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_TUSER_W = 3;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 28;

	localparam logic [19:0] POLL_LIMIT_RST = 20'd1000000;

	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_STATUS = 2'd1;
	localparam logic [1:0] CMD_WORD   = 2'd2;

	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_DRIVE    = 2'd1;
	localparam logic [1:0] REG_POLL     = 2'd2;

	localparam logic [2:0] ACT_REG_WR   = 3'd0;
	localparam logic [2:0] ACT_STAT_RD  = 3'd1;
	localparam logic [2:0] ACT_WORD_RD  = 3'd2;
	localparam logic [2:0] ACT_WORD_WR  = 3'd3;
	localparam logic [2:0] ACT_COMPLETE = 3'd4;

	localparam logic [3:0] PORT_DATA     = 4'd0;
	localparam logic [3:0] PORT_FEATURES = 4'd1;
	localparam logic [3:0] PORT_DEVHEAD  = 4'd6;
	localparam logic [3:0] PORT_CMD      = 4'd7;
	localparam logic [3:0] PORT_ALTSTAT  = 4'd8;

	localparam logic [7:0] ST_BSY = 8'h80;
	localparam logic [7:0] ST_DF  = 8'h20;
	localparam logic [7:0] ST_DRQ = 8'h08;
	localparam logic [7:0] ST_ERR = 8'h01;

	localparam logic [7:0] ATA_READ  = 8'h20;
	localparam logic [7:0] ATA_WRITE = 8'h30;
	localparam logic [7:0] ATA_FLUSH = 8'hE7;
	localparam logic [7:0] DEVHEAD_LBA = 8'hE0;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_SELWAIT = 3'd1;
	localparam logic [2:0] PH_DRQWAIT = 3'd2;
	localparam logic [2:0] PH_DATA    = 3'd3;
	localparam logic [2:0] PH_FLUSH   = 3'd4;

	localparam logic [2:0] RUN_FIN   = 3'd0;
	localparam logic [2:0] RUN_START = 3'd1;
	localparam logic [2:0] RUN_TASK  = 3'd2;
	localparam logic [2:0] RUN_POLL  = 3'd3;
	localparam logic [2:0] RUN_DATA  = 3'd4;

	localparam logic [1:0] TAIL_NONE  = 2'd0;
	localparam logic [1:0] TAIL_NEXT  = 2'd1;
	localparam logic [1:0] TAIL_FLUSH = 2'd2;
	localparam logic [1:0] TAIL_DONE  = 2'd3;

	localparam int LEN_START_I = (DELAY_READS + 2 > MAX_RESULTS) ? MAX_RESULTS : DELAY_READS + 2;
	localparam int LEN_FLUSH_I = (DELAY_READS + 3 > MAX_RESULTS) ? MAX_RESULTS : DELAY_READS + 3;
	localparam logic [3:0] LEN_START = 4'(LEN_START_I);
	localparam logic [3:0] LEN_FLUSH = 4'(LEN_FLUSH_I);
	localparam logic [3:0] LEN_TASK  = 4'd7;
	localparam logic [3:0] LEN_ONE   = 4'd1;
	localparam logic [3:0] DLY_LAST  = 4'(DELAY_READS);

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  tail;
		logic [3:0]  len;
		logic [15:0] value;
		logic [7:0]  sector;
		logic        err;
		logic [7:0]  done;
		logic [23:0] lba;
		logic [7:0]  cnt;
		logic        wr;
	} run_t;

endpackage

`default_nettype wire

/* rtl/core/ata_pio_sector_transfer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Results of an accepted request are registered and appear in the cycle after it is accepted.
// A request produces 1 to 7 results, held while m_axis_tready is low; the next request is
// taken in the cycle the final result of the run is taken, and a request producing no
// result leaves the output empty. The run register and its step counter set this.
// Reset (arst_n low, asynchronous): phase idle, counters zero, output empty,
// capacity 0, drive 0, poll limit 1000000.
module ata_pio_sector_transfer (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_wen,
	input  wire [ata_pio_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire [ata_pio_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// lba[27:0], count[36:28], write[37], status[45:38], word[61:46], zero fill
	input  wire [ata_pio_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// cmd[1:0]
	input  wire [ata_pio_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// port[3:0], value[19:4], sector[27:20], error[28], done_count[36:29], zero fill
	output logic [ata_pio_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// action[2:0]
	output logic [ata_pio_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
	output logic                                  m_axis_tlast
);
	import ata_pio_pkg::*;

	logic [27:0] cap_q;
	logic        drv_q;
	logic [19:0] plim_q;

	logic [2:0]  phase_q, phase_d;
	logic [27:0] lba_q, lba_d;
	logic [7:0]  total_q, total_d;
	logic        wr_q, wr_d;
	logic [7:0]  sector_q, sector_d;
	logic [7:0]  word_idx_q, word_idx_d;
	logic [19:0] poll_q, poll_d;

	run_t        run_q, run_d;
	logic        run_valid_q;
	logic [2:0]  step_q;
	logic        load;

	logic [1:0]  in_cmd;
	logic [27:0] in_lba;
	logic [8:0]  in_cnt;
	logic        in_wr;
	logic [7:0]  in_st;
	logic [15:0] in_word;

	logic        in_acc, out_acc, out_last;
	logic [19:0] poll_inc, poll_lim;
	logic        poll_exp;
	logic [27:0] room;
	logic        bad_range;
	logic [7:0]  sector_inc;
	logic        word_wrap;

	assign in_cmd  = s_axis_tuser[1:0];
	assign in_lba  = s_axis_tdata[27:0];
	assign in_cnt  = s_axis_tdata[36:28];
	assign in_wr   = s_axis_tdata[37];
	assign in_st   = s_axis_tdata[45:38];
	assign in_word = s_axis_tdata[61:46];

	assign out_last      = ({1'b0, step_q} + 4'd1) >= run_q.len;
	assign m_axis_tvalid = run_valid_q;
	assign m_axis_tlast  = out_last;
	assign out_acc       = run_valid_q && m_axis_tready;
	assign s_axis_tready = !run_valid_q || (m_axis_tready && out_last);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign poll_inc   = poll_q + 20'd1;
	assign poll_lim   = (plim_q == 20'd0) ? 20'd1 : plim_q;
	assign poll_exp   = poll_inc >= poll_lim;
	assign room       = cap_q - in_lba;
	assign bad_range  = (in_lba >= cap_q) || ({19'd0, in_cnt} > room) ||
	                    (in_cnt > 9'(MAX_SECTORS));
	assign sector_inc = sector_q + 8'd1;
	assign word_wrap  = ({1'b0, word_idx_q} + 9'd1) >= 9'(WORDS_PER_SECTOR);

	always_comb begin
		phase_d    = phase_q;
		lba_d      = lba_q;
		total_d    = total_q;
		wr_d       = wr_q;
		sector_d   = sector_q;
		word_idx_d = word_idx_q;
		poll_d     = poll_q;
		load       = 1'b0;
		run_d      = '0;
		run_d.lba  = lba_q[23:0];
		run_d.cnt  = total_q;
		run_d.wr   = wr_q;
		run_d.len  = LEN_ONE;
		if (in_cmd == CMD_START && phase_q == PH_IDLE) begin
			load = 1'b1;
			if (in_cnt == 9'd0) begin
				run_d.kind = RUN_FIN;
			end else if (bad_range) begin
				run_d.kind = RUN_FIN;
				run_d.err  = 1'b1;
			end else begin
				lba_d      = in_lba;
				total_d    = in_cnt[7:0];
				wr_d       = in_wr;
				sector_d   = 8'd0;
				word_idx_d = 8'd0;
				poll_d     = 20'd0;
				phase_d    = PH_SELWAIT;
				run_d.kind = RUN_START;
				run_d.len  = LEN_START;
				run_d.value = {8'd0, DEVHEAD_LBA | {3'd0, drv_q, in_lba[27:24]}};
			end
		end else if (in_cmd == CMD_STATUS && phase_q == PH_SELWAIT) begin
			load = 1'b1;
			if ((in_st & ST_BSY) == 8'd0) begin
				poll_d     = 20'd0;
				phase_d    = PH_DRQWAIT;
				run_d.kind = RUN_TASK;
				run_d.len  = LEN_TASK;
			end else begin
				poll_d = poll_inc;
				if (poll_exp) begin
					phase_d    = PH_IDLE;
					run_d.kind = RUN_FIN;
					run_d.err  = 1'b1;
				end else begin
					run_d.kind = RUN_POLL;
				end
			end
		end else if (in_cmd == CMD_STATUS && phase_q == PH_DRQWAIT) begin
			if ((in_st & (ST_ERR | ST_DF)) != 8'd0) begin
				load       = 1'b1;
				phase_d    = PH_IDLE;
				run_d.kind = RUN_FIN;
				run_d.err  = (sector_q == 8'd0);
				run_d.done = sector_q;
			end else if ((in_st & ST_BSY) == 8'd0 && (in_st & ST_DRQ) != 8'd0) begin
				word_idx_d = 8'd0;
				phase_d    = PH_DATA;
			end else begin
				load   = 1'b1;
				poll_d = poll_inc;
				if (poll_exp) begin
					phase_d    = PH_IDLE;
					run_d.kind = RUN_FIN;
					run_d.err  = (sector_q == 8'd0);
					run_d.done = sector_q;
				end else begin
					run_d.kind = RUN_POLL;
				end
			end
		end else if (in_cmd == CMD_WORD && phase_q == PH_DATA) begin
			load         = 1'b1;
			run_d.kind   = RUN_DATA;
			run_d.value  = in_word;
			run_d.sector = sector_q;
			run_d.tail   = TAIL_NONE;
			if (word_wrap) begin
				word_idx_d = 8'd0;
				sector_d   = sector_inc;
				run_d.len  = LEN_START;
				if (sector_inc >= total_q) begin
					if (wr_q) begin
						poll_d     = 20'd0;
						phase_d    = PH_FLUSH;
						run_d.tail = TAIL_FLUSH;
						run_d.len  = LEN_FLUSH;
					end else begin
						phase_d    = PH_IDLE;
						run_d.tail = TAIL_DONE;
						run_d.done = total_q;
					end
				end else begin
					poll_d     = 20'd0;
					phase_d    = PH_DRQWAIT;
					run_d.tail = TAIL_NEXT;
				end
			end else begin
				word_idx_d = word_idx_q + 8'd1;
			end
		end else if (in_cmd == CMD_STATUS && phase_q == PH_FLUSH) begin
			load = 1'b1;
			if ((in_st & ST_BSY) != 8'd0) begin
				poll_d = poll_inc;
			end
			if ((in_st & ST_BSY) == 8'd0 || poll_exp) begin
				phase_d    = PH_IDLE;
				run_d.kind = RUN_FIN;
				run_d.done = total_q;
			end else begin
				run_d.kind = RUN_POLL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= '0;
			drv_q  <= 1'b0;
			plim_q <= POLL_LIMIT_RST;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_CAPACITY: cap_q  <= cfg_wdata;
				REG_DRIVE:    drv_q  <= cfg_wdata[0];
				REG_POLL:     plim_q <= cfg_wdata[19:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			lba_q      <= '0;
			total_q    <= '0;
			wr_q       <= 1'b0;
			sector_q   <= '0;
			word_idx_q <= '0;
			poll_q     <= '0;
		end else if (in_acc) begin
			phase_q    <= phase_d;
			lba_q      <= lba_d;
			total_q    <= total_d;
			wr_q       <= wr_d;
			sector_q   <= sector_d;
			word_idx_q <= word_idx_d;
			poll_q     <= poll_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (in_acc) begin
			run_valid_q <= load;
			step_q      <= '0;
		end else if (out_acc) begin
			if (out_last) begin
				run_valid_q <= 1'b0;
				step_q      <= '0;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && load) begin
			run_q <= run_d;
		end
	end

	logic [3:0]  s4;
	logic [2:0]  r_act;
	logic [3:0]  r_port;
	logic [15:0] r_val;
	logic [7:0]  r_sec;
	logic        r_err;
	logic [7:0]  r_done;

	assign s4 = {1'b0, step_q};

	always_comb begin
		r_act  = ACT_STAT_RD;
		r_port = PORT_CMD;
		r_val  = '0;
		r_sec  = '0;
		r_err  = 1'b0;
		r_done = '0;
		unique case (run_q.kind)
			RUN_FIN: begin
				r_act  = ACT_COMPLETE;
				r_port = PORT_DATA;
				r_err  = run_q.err;
				r_done = run_q.done;
			end
			RUN_START: begin
				if (s4 == 4'd0) begin
					r_act  = ACT_REG_WR;
					r_port = PORT_DEVHEAD;
					r_val  = run_q.value;
				end else if (s4 <= DLY_LAST) begin
					r_port = PORT_ALTSTAT;
				end
			end
			RUN_TASK: begin
				if (s4 < 4'd6) begin
					r_act  = ACT_REG_WR;
					r_port = (s4 == 4'd5) ? PORT_CMD : PORT_FEATURES + s4;
					case (step_q)
						3'd1:    r_val = {8'd0, run_q.cnt};
						3'd2:    r_val = {8'd0, run_q.lba[7:0]};
						3'd3:    r_val = {8'd0, run_q.lba[15:8]};
						3'd4:    r_val = {8'd0, run_q.lba[23:16]};
						3'd5:    r_val = {8'd0, run_q.wr ? ATA_WRITE : ATA_READ};
						default: r_val = '0;
					endcase
				end
			end
			RUN_POLL: ;
			RUN_DATA: begin
				if (s4 == 4'd0) begin
					r_act  = run_q.wr ? ACT_WORD_WR : ACT_WORD_RD;
					r_port = PORT_DATA;
					r_val  = run_q.value;
					r_sec  = run_q.sector;
				end else if (s4 <= DLY_LAST) begin
					r_port = PORT_ALTSTAT;
				end else if (s4 == DLY_LAST + 4'd1) begin
					if (run_q.tail == TAIL_FLUSH) begin
						r_act = ACT_REG_WR;
						r_val = {8'd0, ATA_FLUSH};
					end else if (run_q.tail == TAIL_DONE) begin
						r_act  = ACT_COMPLETE;
						r_port = PORT_DATA;
						r_done = run_q.done;
					end
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tdata = {3'd0, r_done, r_err, r_sec, r_val, r_port};
	assign m_axis_tuser = r_act;

`ifndef SYNTHESIS
	a_step_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> (s4 < run_q.len))
		else $error("step counter ran past the run length");
	a_accept_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (!run_valid_q || (out_acc && out_last)))
		else $error("request taken while a run is still being delivered");
	a_err_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ACT_COMPLETE && m_axis_tdata[28])
		|-> (m_axis_tdata[36:29] == 8'd0))
		else $error("failed completion reports sectors done");
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA || phase_q == PH_DRQWAIT) |-> (sector_q < total_q))
		else $error("sector index beyond transfer length");
`endif

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import ata_pio_pkg::*;

	localparam logic [1:0] CMD_NONE     = 2'd3;
	localparam logic [3:0] PORT_COUNT   = 4'd2;
	localparam logic [3:0] PORT_LBA_LO  = 4'd3;
	localparam logic [3:0] PORT_LBA_MID = 4'd4;
	localparam logic [3:0] PORT_LBA_HI  = 4'd5;
	localparam logic [27:0] LBA_TOP     = 28'hFFFFFFF;
	localparam int STALL_LIMIT          = 2000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [27:0] lba;
		logic [8:0]  count;
		logic        wr;
		logic [7:0]  status;
		logic [15:0] word;
	} ata_req_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  port;
		logic [15:0] value;
		logic [7:0]  sector;
		logic        err;
		logic [7:0]  done;
		logic        last;
	} bus_op_t;

	typedef enum logic [1:0] {ROW_REQ, ROW_CFG, ROW_SECTOR} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		ata_req_t    rq;
		bit          typed;
		bus_op_t     want;
		logic [1:0]  reg_idx;
		logic [27:0] reg_val;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wen = 1'b0;
	logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	wire                    s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
	wire                    m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	wire [OUT_TDATA_W-1:0]  m_axis_tdata;
	wire [OUT_TUSER_W-1:0]  m_axis_tuser;
	wire                    m_axis_tlast;

	ata_pio_sector_transfer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// sequencer copy
	logic [27:0] cap_q = '0;
	logic        drv_q = 1'b0;
	logic [19:0] poll_lim_q = POLL_LIMIT_RST;
	logic [2:0]  ph = PH_IDLE;
	logic [27:0] xfer_lba = '0;
	logic [7:0]  xfer_total = '0;
	logic        xfer_wr = 1'b0;
	logic [7:0]  sec_idx = '0;
	logic [7:0]  word_idx = '0;
	logic [19:0] polls = '0;

	bus_op_t   run_ops[$];
	bus_op_t   pending_ops[$];
	stim_row_t dir_rows[$];

	bit quiet = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int n_reqs = 0;
	int n_checked = 0;
	int completions = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		if (mismatches <= 30)
			$display("%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
	endtask

	task automatic add_op(input logic [2:0] a, input logic [3:0] p, input logic [15:0] v,
		input logic [7:0] s, input logic e, input logic [7:0] d);
		bus_op_t op;
		op = '{a, p, v, s, e, d, 1'b0};
		if (run_ops.size() < MAX_RESULTS)
			run_ops.push_back(op);
	endtask

	task automatic close_run(input logic e, input logic [7:0] d);
		add_op(ACT_COMPLETE, PORT_DATA, 16'h0000, 8'h00, e, d);
		ph = PH_IDLE;
		completions++;
	endtask

	task automatic alt_status_reads();
		repeat (DELAY_READS) add_op(ACT_STAT_RD, PORT_ALTSTAT, 16'h0000, 8'h00, 1'b0, 8'h00);
	endtask

	task automatic status_request();
		add_op(ACT_STAT_RD, PORT_CMD, 16'h0000, 8'h00, 1'b0, 8'h00);
	endtask

	task automatic abort_transfer();
		if (sec_idx == 8'h00)
			close_run(1'b1, 8'h00);
		else
			close_run(1'b0, sec_idx);
	endtask

	function automatic logic poll_expired();
		logic [19:0] lim;
		lim = (poll_lim_q == 20'd0) ? 20'd1 : poll_lim_q;
		polls = polls + 20'd1;
		return polls >= lim;
	endfunction

	task automatic advance_sequencer(input ata_req_t r);
		logic [31:0] room;
		bus_op_t tail;
		run_ops.delete();
		room = {4'h0, cap_q} - {4'h0, r.lba};
		if (r.cmd == CMD_START && ph == PH_IDLE) begin
			if (r.count == 9'd0) begin
				close_run(1'b0, 8'h00);
			end else if (r.lba >= cap_q || {23'd0, r.count} > room ||
				r.count > 9'(MAX_SECTORS)) begin
				close_run(1'b1, 8'h00);
			end else begin
				xfer_lba = r.lba;
				xfer_total = r.count[7:0];
				xfer_wr = r.wr;
				sec_idx = '0;
				word_idx = '0;
				polls = '0;
				add_op(ACT_REG_WR, PORT_DEVHEAD,
					{8'h00, DEVHEAD_LBA | {3'b000, drv_q, r.lba[27:24]}}, 8'h00, 1'b0, 8'h00);
				alt_status_reads();
				status_request();
				ph = PH_SELWAIT;
			end
		end else if (r.cmd == CMD_STATUS && ph == PH_SELWAIT) begin
			if ((r.status & ST_BSY) == 8'h00) begin
				add_op(ACT_REG_WR, PORT_FEATURES, 16'h0000, 8'h00, 1'b0, 8'h00);
				add_op(ACT_REG_WR, PORT_COUNT, {8'h00, xfer_total}, 8'h00, 1'b0, 8'h00);
				add_op(ACT_REG_WR, PORT_LBA_LO, {8'h00, xfer_lba[7:0]}, 8'h00, 1'b0, 8'h00);
				add_op(ACT_REG_WR, PORT_LBA_MID, {8'h00, xfer_lba[15:8]}, 8'h00, 1'b0, 8'h00);
				add_op(ACT_REG_WR, PORT_LBA_HI, {8'h00, xfer_lba[23:16]}, 8'h00, 1'b0, 8'h00);
				add_op(ACT_REG_WR, PORT_CMD, {8'h00, xfer_wr ? ATA_WRITE : ATA_READ},
					8'h00, 1'b0, 8'h00);
				status_request();
				polls = '0;
				ph = PH_DRQWAIT;
			end else if (poll_expired()) begin
				close_run(1'b1, 8'h00);
			end else begin
				status_request();
			end
		end else if (r.cmd == CMD_STATUS && ph == PH_DRQWAIT) begin
			if ((r.status & (ST_ERR | ST_DF)) != 8'h00) begin
				abort_transfer();
			end else if ((r.status & ST_BSY) == 8'h00 && (r.status & ST_DRQ) != 8'h00) begin
				word_idx = '0;
				ph = PH_DATA;
			end else if (poll_expired()) begin
				abort_transfer();
			end else begin
				status_request();
			end
		end else if (r.cmd == CMD_WORD && ph == PH_DATA) begin
			add_op(xfer_wr ? ACT_WORD_WR : ACT_WORD_RD, PORT_DATA, r.word, sec_idx, 1'b0, 8'h00);
			if ({24'd0, word_idx} + 1 >= WORDS_PER_SECTOR) begin
				word_idx = '0;
				alt_status_reads();
				sec_idx = sec_idx + 8'd1;
				if (sec_idx >= xfer_total) begin
					if (xfer_wr) begin
						add_op(ACT_REG_WR, PORT_CMD, {8'h00, ATA_FLUSH}, 8'h00, 1'b0, 8'h00);
						status_request();
						polls = '0;
						ph = PH_FLUSH;
					end else begin
						close_run(1'b0, xfer_total);
					end
				end else begin
					status_request();
					polls = '0;
					ph = PH_DRQWAIT;
				end
			end else begin
				word_idx = word_idx + 8'd1;
			end
		end else if (r.cmd == CMD_STATUS && ph == PH_FLUSH) begin
			if ((r.status & ST_BSY) == 8'h00 || poll_expired())
				close_run(1'b0, xfer_total);
			else
				status_request();
		end
		if (run_ops.size() > 0) begin
			tail = run_ops.pop_back();
			tail.last = 1'b1;
			run_ops.push_back(tail);
		end
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_req(input ata_req_t r, input bit typed, input bus_op_t want);
		if (!quiet && $urandom_range(0, 4) == 0)
			pause_sender($urandom_range(1, 14));
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.cmd;
		s_axis_tdata <= {2'b00, r.word, r.status, r.wr, r.count, r.lba};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		advance_sequencer(r);
		n_reqs++;
		if (typed)
			pending_ops.push_back(want);
		else
			foreach (run_ops[i]) pending_ops.push_back(run_ops[i]);
	endtask

	task automatic settle_outputs();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_ops.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [27:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_CAPACITY: cap_q = val;
			REG_DRIVE:    drv_q = val[0];
			REG_POLL:     poll_lim_q = val[19:0];
			default: ;
		endcase
	endtask

	task automatic next_random_req(output ata_req_t r);
		int unsigned k, room, capn;
		r.lba = 28'($urandom);
		r.count = 9'($urandom);
		r.wr = 1'($urandom);
		r.status = 8'($urandom);
		r.word = 16'($urandom);
		capn = cap_q;
		k = $urandom_range(0, 99);
		if (ph != PH_IDLE && k < 3) begin
			case ($urandom_range(0, 2))
				0: r.cmd = CMD_START;
				1: r.cmd = (ph == PH_DATA) ? CMD_STATUS : CMD_WORD;
				default: r.cmd = CMD_NONE;
			endcase
		end else begin
			case (ph)
				PH_IDLE: begin
					if (k < 10) begin
						r.cmd = 2'($urandom_range(CMD_STATUS, CMD_NONE));
					end else begin
						r.cmd = CMD_START;
						if (k < 17) begin
							r.count = 9'd0;
						end else if (k < 24) begin
							r.count = 9'($urandom_range(MAX_SECTORS + 1, 511));
						end else if (k < 32 || capn == 0) begin
							r.count = 9'($urandom_range(1, MAX_SECTORS));
							if (cap_q == LBA_TOP || capn == 0 || $urandom_range(0, 1)) begin
								r.lba = 28'($urandom_range(capn, LBA_TOP));
							end else begin
								room = $urandom_range(1, (capn < 254) ? capn : 254);
								r.lba = 28'(capn - room);
								r.count = 9'($urandom_range(room + 1, MAX_SECTORS));
							end
						end else begin
							if ($urandom_range(0, 4) == 0)
								r.lba = 28'(capn - $urandom_range(1, (capn < 4) ? capn : 4));
							else
								r.lba = 28'($urandom_range(0, capn - 1));
							room = capn - r.lba;
							k = $urandom_range(0, 9);
							r.count = (k < 7) ? 9'd1 : ((k < 9) ? 9'd2 : 9'd3);
							if (r.count > room)
								r.count = 9'(room);
						end
					end
				end
				PH_SELWAIT: begin
					r.cmd = CMD_STATUS;
					if (k < 30)
						r.status |= ST_BSY;
					else
						r.status &= ~ST_BSY;
				end
				PH_DRQWAIT: begin
					r.cmd = CMD_STATUS;
					if (k < 20) begin
						r.status |= ($urandom_range(0, 1) ? ST_ERR : ST_DF);
					end else begin
						r.status &= ~(ST_ERR | ST_DF);
						if ($urandom_range(0, 1))
							r.status |= ST_BSY;
						else
							r.status &= ~ST_DRQ;
					end
				end
				PH_DATA: r.cmd = CMD_WORD;
				PH_FLUSH: begin
					r.cmd = CMD_STATUS;
					if (k < 40)
						r.status |= ST_BSY;
					else
						r.status &= ~ST_BSY;
				end
				default: r.cmd = CMD_NONE;
			endcase
		end
	endtask

	task automatic run_setting(input logic [27:0] cap, input logic drv, input logic [19:0] lim,
		input bit no_idle);
		ata_req_t rq;
		int goal;
		settle_outputs();
		write_reg(REG_CAPACITY, cap);
		write_reg(REG_DRIVE, {27'd0, drv});
		write_reg(REG_POLL, {8'd0, lim});
		quiet = no_idle;
		goal = completions + 3;
		while (completions < goal || ph != PH_IDLE) begin
			if (!quiet && ph == PH_IDLE && $urandom_range(0, 9) == 0)
				settle_outputs();
			next_random_req(rq);
			send_req(rq, 1'b0, '0);
		end
	endtask

	function automatic stim_row_t req_row(input logic [1:0] cmd, input logic [27:0] lba,
		input logic [8:0] cnt, input logic wr, input logic [7:0] st);
		stim_row_t row;
		row.kind = ROW_REQ;
		row.rq = '{cmd, lba, cnt, wr, st, 16'hA55A};
		row.typed = 1'b0;
		row.want = '0;
		row.reg_idx = '0;
		row.reg_val = '0;
		return row;
	endfunction

	function automatic stim_row_t done_row(input logic [1:0] cmd, input logic [27:0] lba,
		input logic [8:0] cnt, input logic wr, input logic [7:0] st, input logic e,
		input logic [7:0] d);
		stim_row_t row;
		row = req_row(cmd, lba, cnt, wr, st);
		row.typed = 1'b1;
		row.want = '{ACT_COMPLETE, PORT_DATA, 16'h0000, 8'h00, e, d, 1'b1};
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [27:0] val);
		stim_row_t row;
		row = req_row(CMD_NONE, '0, '0, 1'b0, '0);
		row.kind = ROW_CFG;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	function automatic stim_row_t sector_row();
		stim_row_t row;
		row = req_row(CMD_WORD, '0, '0, 1'b0, '0);
		row.kind = ROW_SECTOR;
		return row;
	endfunction

	always @(negedge clk) begin : result_backpressure
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 13);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		bus_op_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tdata[27:20],
				m_axis_tdata[28], m_axis_tdata[36:29], m_axis_tlast};
			if (pending_ops.size() == 0) begin
				report_mismatch("unexpected result", 32'(got), 32'd0);
			end else begin
				want = pending_ops.pop_front();
				n_checked++;
				if (got.action !== want.action)
					report_mismatch("action", 32'(got.action), 32'(want.action));
				if (got.port !== want.port)
					report_mismatch("port", 32'(got.port), 32'(want.port));
				if (got.value !== want.value)
					report_mismatch("value", 32'(got.value), 32'(want.value));
				if (got.sector !== want.sector)
					report_mismatch("sector", 32'(got.sector), 32'(want.sector));
				if (got.err !== want.err)
					report_mismatch("error", 32'(got.err), 32'(want.err));
				if (got.done !== want.done)
					report_mismatch("done_count", 32'(got.done), 32'(want.done));
				if (got.last !== want.last)
					report_mismatch("last", 32'(got.last), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("ata_pio_sector_transfer: mismatch");
				$finish;
			end
		end
	end

	initial begin : stimulus
		ata_req_t rq;
		// reset defaults: capacity 0 rejects every nonzero count
		dir_rows.push_back(done_row(CMD_START,  28'h0000000,   9'd0, 1'b0, 8'h00, 1'b0, 8'd0));
		dir_rows.push_back(done_row(CMD_START,  28'h0000000,   9'd1, 1'b0, 8'h00, 1'b1, 8'd0));
		dir_rows.push_back(done_row(CMD_START,  LBA_TOP,     9'd511, 1'b1, 8'hFF, 1'b1, 8'd0));
		dir_rows.push_back(req_row(CMD_STATUS,  28'h0000000,   9'd0, 1'b0, 8'h00));
		dir_rows.push_back(req_row(CMD_WORD,    28'h0000000,   9'd0, 1'b0, 8'h00));
		dir_rows.push_back(req_row(CMD_NONE,    LBA_TOP,     9'd511, 1'b1, 8'hFF));
		dir_rows.push_back(cfg_row(REG_CAPACITY, LBA_TOP));
		dir_rows.push_back(cfg_row(REG_DRIVE,    28'd1));
		dir_rows.push_back(cfg_row(REG_POLL,     28'd3));
		dir_rows.push_back(done_row(CMD_START,  LBA_TOP,       9'd1, 1'b0, 8'h00, 1'b1, 8'd0));
		dir_rows.push_back(done_row(CMD_START,  28'hFFFFFFE,   9'd2, 1'b0, 8'h00, 1'b1, 8'd0));
		dir_rows.push_back(done_row(CMD_START,  28'h0000000, 9'd256, 1'b0, 8'h00, 1'b1, 8'd0));
		// select wait runs out of polls
		dir_rows.push_back(req_row(CMD_START,   28'hFFFFFFE,   9'd1, 1'b0, 8'h00));
		dir_rows.push_back(req_row(CMD_START,   28'h0000005,   9'd1, 1'b0, 8'h00));
		dir_rows.push_back(req_row(CMD_STATUS,  28'h0000000,   9'd0, 1'b0, 8'h80));
		dir_rows.push_back(req_row(CMD_STATUS,  28'h0000000,   9'd0, 1'b0, 8'hFF));
		dir_rows.push_back(done_row(CMD_STATUS, 28'h0000000,   9'd0, 1'b0, 8'h80, 1'b1, 8'd0));
		// one-sector write, flush runs out of polls
		dir_rows.push_back(req_row(CMD_START,   28'h5A5A5A5,   9'd1, 1'b1, 8'h00));
		dir_rows.push_back(req_row(CMD_STATUS,  28'h0000000,   9'd0, 1'b0, 8'h00));
		dir_rows.push_back(req_row(CMD_STATUS,  28'h0000000,   9'd0, 1'b0, 8'h88));
		dir_rows.push_back(req_row(CMD_STATUS,  28'h0000000,   9'd0, 1'b0, 8'h08));
		dir_rows.push_back(sector_row());
		dir_rows.push_back(req_row(CMD_STATUS,  28'h0000000,   9'd0, 1'b0, 8'h80));
		dir_rows.push_back(req_row(CMD_STATUS,  28'h0000000,   9'd0, 1'b0, 8'hFF));
		dir_rows.push_back(done_row(CMD_STATUS, 28'h0000000,   9'd0, 1'b0, 8'h80, 1'b0, 8'd1));
		// full count, device error before any sector
		dir_rows.push_back(req_row(CMD_START,   28'h0000000, 9'd255, 1'b0, 8'h00));
		dir_rows.push_back(req_row(CMD_STATUS,  28'h0000000,   9'd0, 1'b0, 8'h7F));
		dir_rows.push_back(done_row(CMD_STATUS, 28'h0000000,   9'd0, 1'b0, 8'h21, 1'b1, 8'd0));
		// device fault after one sector: partial count
		dir_rows.push_back(req_row(CMD_START,   28'h1000000,   9'd2, 1'b0, 8'h00));
		dir_rows.push_back(req_row(CMD_STATUS,  28'h0000000,   9'd0, 1'b0, 8'h00));
		dir_rows.push_back(req_row(CMD_STATUS,  28'h0000000,   9'd0, 1'b0, 8'h08));
		dir_rows.push_back(sector_row());
		dir_rows.push_back(done_row(CMD_STATUS, 28'h0000000,   9'd0, 1'b0, 8'h28, 1'b0, 8'd1));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CFG: begin
					settle_outputs();
					write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
				end
				ROW_SECTOR: begin
					repeat (WORDS_PER_SECTOR) begin
						next_random_req(rq);
						rq.cmd = CMD_WORD;
						send_req(rq, 1'b0, '0);
					end
				end
				default: send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
			endcase
		end

		run_setting(LBA_TOP, 1'b0, POLL_LIMIT_RST, 1'b0);
		run_setting(28'd300, 1'b1, 20'd0, 1'b0);
		run_setting(28'd1, 1'b0, 20'd2, 1'b0);
		run_setting(28'($urandom), 1'($urandom), 20'hFFFFF, 1'b0);
		run_setting(LBA_TOP, 1'b1, 20'd4, 1'b1);

		settle_outputs();
		repeat (4) @(posedge clk);
		$display("%0d requests sent, %0d results checked, %0d transfers closed", n_reqs,
			n_checked, completions);
		$display("covered range and count rejects, poll timeouts, device errors, flush waits");
		if (mismatches == 0)
			$display("ata_pio_sector_transfer: match");
		else
			$display("ata_pio_sector_transfer: mismatch");
		$finish;
	end

endmodule
